FILE: sv/smrt_pkg.sv
// package: shared types, codes and defaults for the segment merge block
`timescale 1ns / 1ps
package smrt_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_LEAVES_DEF  = 32;
  localparam int KEY_BITS_DEF    = 32;
  localparam int ROW_BITS        = 10;
  localparam int RANGE_BITS      = 11;

  localparam logic [2:0] OP_WR_ELEM = 3'd0;
  localparam logic [2:0] OP_RD_ELEM = 3'd1;
  localparam logic [2:0] OP_WR_SEG  = 3'd2;
  localparam logic [2:0] OP_RD_SEG  = 3'd3;
  localparam logic [2:0] OP_MERGE   = 3'd4;

  typedef enum logic [2:0] {
    K_WR_ELEM,
    K_RD_ELEM,
    K_WR_SEG,
    K_RD_SEG,
    K_MERGE,
    K_REJECT
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [9:0]   pos;
    logic [31:0]  key;
    logic [9:0]   row;
    logic [6:0]   sa;
    logic [6:0]   sb;
    logic [10:0]  rf;
    logic [10:0]  rl;
  } cmd_t;

  typedef struct packed {
    logic         status;
    logic [10:0]  limit;
    logic [10:0]  first;
    logic [9:0]   row;
    logic [31:0]  key;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ISSUE,
    S_MA,
    S_MB,
    S_CHECK,
    S_LD_L,
    S_LD_R,
    S_CAPR,
    S_CAPL,
    S_STEP,
    S_SH_RD,
    S_SH_WR,
    S_SW_RD,
    S_SW_WR,
    S_CP_RD,
    S_CP_WR,
    S_FIN_L,
    S_FIN_R,
    S_DONE
  } st_t;

endpackage

FILE: sv/smrt_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module smrt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: sv/smrt_front.sv
// front end: decodes and checks operations, holds them in a two entry queue
`timescale 1ns / 1ps
module smrt_front #(
  parameter int STORE_DEPTH = smrt_pkg::STORE_DEPTH_DEF,
  parameter int MAX_LEAVES  = smrt_pkg::MAX_LEAVES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  output logic           in_rdy,
  input  logic [2:0]     in_op,
  input  smrt_pkg::cmd_t in_cmd,
  output logic           q_vld,
  output smrt_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  import smrt_pkg::*;

  localparam int SEG_COUNT = 2 * MAX_LEAVES + 1;

  cmd_t        q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        cls;
  logic        push;
  logic        pos_ok, sa_ok, sb_ok;

  assign pos_ok = 32'(in_cmd.pos) < 32'(STORE_DEPTH);
  assign sa_ok  = 32'(in_cmd.sa) < 32'(SEG_COUNT);
  assign sb_ok  = 32'(in_cmd.sb) < 32'(SEG_COUNT);

  always_comb begin
    cls = in_cmd;
    unique case (in_op)
      OP_WR_ELEM: cls.kind = pos_ok ? K_WR_ELEM : K_REJECT;
      OP_RD_ELEM: cls.kind = pos_ok ? K_RD_ELEM : K_REJECT;
      OP_WR_SEG:  cls.kind = sa_ok ? K_WR_SEG : K_REJECT;
      OP_RD_SEG:  cls.kind = sa_ok ? K_RD_SEG : K_REJECT;
      OP_MERGE:   cls.kind = (sa_ok && sb_ok) ? K_MERGE : K_REJECT;
      default:    cls.kind = K_REJECT;
    endcase
  end

  assign in_rdy = cnt_r != 2'd2;
  assign push   = in_vld && in_rdy;
  assign q_vld  = cnt_r != 2'd0;
  assign q_cmd  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule

FILE: sv/smrt_back.sv
// back end: runs element and range accesses and the merge sequence
`timescale 1ns / 1ps
module smrt_back #(
  parameter int STORE_DEPTH = smrt_pkg::STORE_DEPTH_DEF,
  parameter int MAX_LEAVES  = smrt_pkg::MAX_LEAVES_DEF,
  parameter int KEY_BITS    = smrt_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  smrt_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_vld,
  output smrt_pkg::res_t out_res,
  input  logic           out_rdy
);
  import smrt_pkg::*;

  localparam int SEG_COUNT = 2 * MAX_LEAVES + 1;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = $clog2(SEG_COUNT);
  localparam int EW = KEY_BITS + ROW_BITS;
  localparam int GW = 2 * RANGE_BITS;

  st_t st_r, st_nxt;
  cmd_t cmd_r;
  logic st_bad_r;
  logic out_vld_r;
  res_t out_r, res_new;

  logic [10:0] ls_r, le_r, rs_r, re_r, rlen_r, bnd_r;
  logic [10:0] i_r, j_r, n_r, k_r;
  logic [10:0] ga_st_r, ga_en_r;
  logic [6:0]  lft_r, rgt_r;
  logic [SW-1:0] sk_r;
  logic [EW-1:0] hl_r, hr_r;
  logic [SEG_COUNT-1:0] g_vld_r;
  logic g_rv_r;

  logic e_we, e_re, s_we, s_re, g_we, g_re;
  logic [AW-1:0] e_waddr, e_raddr, s_waddr, s_raddr;
  logic [EW-1:0] e_wdata, e_rdata, s_wdata, s_rdata;
  logic [SW-1:0] g_waddr, g_raddr;
  logic [GW-1:0] g_wdata, g_rdata;
  logic [10:0] seg_st, seg_en;
  logic take_l, key_le, a_low, m_bad, m_end, in_gap, load_out;

  smrt_ram #(.W(EW), .D(STORE_DEPTH)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );
  smrt_ram #(.W(EW), .D(STORE_DEPTH)) u_scr (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );
  smrt_ram #(.W(GW), .D(SEG_COUNT)) u_seg (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );

  // never written range entries read as zero
  assign seg_st = g_rv_r ? g_rdata[GW-1:RANGE_BITS] : 11'd0;
  assign seg_en = g_rv_r ? g_rdata[RANGE_BITS-1:0] : 11'd0;

  assign key_le = $signed(hl_r[EW-1:ROW_BITS]) <= $signed(hr_r[EW-1:ROW_BITS]);
  assign take_l = (i_r < le_r) && ((j_r >= re_r) || key_le);
  assign m_end  = (i_r == le_r) && (j_r == re_r);
  assign a_low  = ga_st_r < seg_st;
  assign m_bad  = (ls_r > le_r) || (rs_r > re_r) || (le_r > rs_r) ||
                  (32'(re_r) > 32'(STORE_DEPTH));
  assign in_gap = (seg_st >= le_r) && (seg_en <= rs_r);
  assign load_out = (st_r == S_DONE) && (!out_vld_r || out_rdy);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_vld) st_nxt = S_ISSUE;
      S_ISSUE: st_nxt = (cmd_r.kind == K_MERGE) ? S_MA : S_DONE;
      S_MA:    st_nxt = S_MB;
      S_MB:    st_nxt = (ga_st_r == seg_st) ? S_DONE : S_CHECK;
      S_CHECK: st_nxt = m_bad ? S_DONE : S_LD_L;
      S_LD_L:  st_nxt = S_LD_R;
      S_LD_R:  st_nxt = S_CAPR;
      S_CAPR:  st_nxt = S_STEP;
      S_CAPL:  st_nxt = S_STEP;
      S_STEP: begin
        if (m_end) st_nxt = S_SH_RD;
        else       st_nxt = take_l ? S_CAPL : S_CAPR;
      end
      S_SH_RD: st_nxt = (k_r > bnd_r) ? S_SH_WR : S_SW_RD;
      S_SH_WR: st_nxt = S_SH_RD;
      S_SW_RD: st_nxt = S_SW_WR;
      S_SW_WR: st_nxt = (32'(sk_r) == SEG_COUNT - 1) ? S_CP_RD : S_SW_RD;
      S_CP_RD: st_nxt = (k_r < n_r) ? S_CP_WR : S_FIN_L;
      S_CP_WR: st_nxt = S_CP_RD;
      S_FIN_L: st_nxt = S_FIN_R;
      S_FIN_R: st_nxt = S_DONE;
      S_DONE:  if (!out_vld_r || out_rdy) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    e_we = 1'b0; e_re = 1'b0; s_we = 1'b0; s_re = 1'b0; g_we = 1'b0; g_re = 1'b0;
    e_waddr = AW'(cmd_r.pos);
    e_raddr = AW'(cmd_r.pos);
    e_wdata = {KEY_BITS'($signed(cmd_r.key)), cmd_r.row};
    s_waddr = AW'(n_r);
    s_raddr = AW'(k_r);
    s_wdata = take_l ? hl_r : hr_r;
    g_waddr = SW'(cmd_r.sa);
    g_raddr = SW'(cmd_r.sa);
    g_wdata = {cmd_r.rf, cmd_r.rl};
    unique case (st_r)
      S_IDLE: q_pop = q_vld;
      S_ISSUE: begin
        unique case (cmd_r.kind)
          K_WR_ELEM: e_we = 1'b1;
          K_RD_ELEM: e_re = 1'b1;
          K_WR_SEG:  g_we = 1'b1;
          K_RD_SEG, K_MERGE: g_re = 1'b1;
          default: ;
        endcase
      end
      S_MA: begin
        g_re = 1'b1;
        g_raddr = SW'(cmd_r.sb);
      end
      S_LD_L: begin
        e_re = 1'b1;
        e_raddr = AW'(i_r);
      end
      S_LD_R: begin
        e_re = 1'b1;
        e_raddr = AW'(j_r);
      end
      S_STEP: begin
        if (!m_end) begin
          s_we = 1'b1;
          e_re = 1'b1;
          e_raddr = take_l ? AW'(i_r + 11'd1) : AW'(j_r + 11'd1);
        end
      end
      S_SH_RD: begin
        e_re = k_r > bnd_r;
        e_raddr = AW'(k_r - 11'd1 - rlen_r);
      end
      S_SH_WR: begin
        e_we = 1'b1;
        e_waddr = AW'(k_r - 11'd1);
        e_wdata = e_rdata;
      end
      S_SW_RD: begin
        g_re = 1'b1;
        g_raddr = sk_r;
      end
      S_SW_WR: begin
        g_we = in_gap;
        g_waddr = sk_r;
        g_wdata = {seg_st + rlen_r, seg_en + rlen_r};
      end
      S_CP_RD: s_re = k_r < n_r;
      S_CP_WR: begin
        e_we = 1'b1;
        e_waddr = AW'(ls_r + k_r);
        e_wdata = s_rdata;
      end
      S_FIN_L: begin
        g_we = 1'b1;
        g_waddr = SW'(lft_r);
        g_wdata = {ls_r, bnd_r};
      end
      S_FIN_R: begin
        g_we = 1'b1;
        g_waddr = SW'(rgt_r);
        g_wdata = {ls_r, bnd_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    res_new = '0;
    res_new.status = st_bad_r;
    if (cmd_r.kind == K_RD_ELEM) begin
      res_new.key = 32'(e_rdata[EW-1:ROW_BITS]);
      res_new.row = e_rdata[ROW_BITS-1:0];
    end
    if (cmd_r.kind == K_RD_SEG) begin
      res_new.first = seg_st;
      res_new.limit = seg_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_vld_r <= 1'b0;
      g_vld_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (load_out) out_vld_r <= 1'b1;
      else if (out_rdy) out_vld_r <= 1'b0;
      if (g_we) g_vld_r[g_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (g_re) g_rv_r <= g_vld_r[g_raddr];
    if (load_out) out_r <= res_new;
    unique case (st_r)
      S_IDLE: cmd_r <= q_cmd;
      S_ISSUE: st_bad_r <= cmd_r.kind == K_REJECT;
      S_MA: begin
        ga_st_r <= seg_st;
        ga_en_r <= seg_en;
      end
      S_MB: begin
        st_bad_r <= ga_st_r == seg_st;
        lft_r <= a_low ? cmd_r.sa : cmd_r.sb;
        rgt_r <= a_low ? cmd_r.sb : cmd_r.sa;
        ls_r  <= a_low ? ga_st_r : seg_st;
        le_r  <= a_low ? ga_en_r : seg_en;
        rs_r  <= a_low ? seg_st : ga_st_r;
        re_r  <= a_low ? seg_en : ga_en_r;
      end
      S_CHECK: begin
        st_bad_r <= m_bad;
        rlen_r <= re_r - rs_r;
        bnd_r  <= le_r + (re_r - rs_r);
        i_r <= ls_r;
        j_r <= rs_r;
        n_r <= 11'd0;
        k_r <= re_r;
      end
      S_LD_R: hl_r <= e_rdata;
      S_CAPL: hl_r <= e_rdata;
      S_CAPR: hr_r <= e_rdata;
      S_STEP: begin
        if (!m_end) begin
          n_r <= n_r + 11'd1;
          if (take_l) i_r <= i_r + 11'd1;
          else        j_r <= j_r + 11'd1;
        end
        sk_r <= '0;
      end
      S_SH_WR: k_r <= k_r - 11'd1;
      S_SW_WR: begin
        sk_r <= sk_r + SW'(1);
        k_r  <= 11'd0;
      end
      S_CP_WR: k_r <= k_r + 11'd1;
      default: ;
    endcase
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;
endmodule

FILE: sv/segment_merge_with_range_table.sv
// top level: segment merge engine with a range table
`timescale 1ns / 1ps
// Takes one operation at a time. A merge of a left and a right run with a gap between
// them first merges both runs into scratch, then moves the gap, sweeps the range
// table and copies the merged run back; each element move needs its own read on
// the single read port of the element store. A two entry queue takes new operations
// while one runs, and the result waits in an output register. Reading an element
// never written gives an undefined value; never written ranges read as zero.
module segment_merge_with_range_table #(
  parameter int STORE_DEPTH = smrt_pkg::STORE_DEPTH_DEF,
  parameter int MAX_LEAVES  = smrt_pkg::MAX_LEAVES_DEF,
  parameter int KEY_BITS    = smrt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // position, key_value, row_number, segment_a,
                                 // segment_b, range_first, range_limit
  input  logic [2:0]  in_tuser,  // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata  // read_key, read_row, read_first, read_limit,
                                 // status, zero pad
);
  import smrt_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_vld, q_pop;

  always_comb begin
    in_cmd.kind = K_REJECT;
    in_cmd.pos  = in_tdata[9:0];
    in_cmd.key  = in_tdata[41:10];
    in_cmd.row  = in_tdata[51:42];
    in_cmd.sa   = in_tdata[58:52];
    in_cmd.sb   = in_tdata[65:59];
    in_cmd.rf   = in_tdata[76:66];
    in_cmd.rl   = in_tdata[87:77];
  end

  smrt_front #(.STORE_DEPTH(STORE_DEPTH), .MAX_LEAVES(MAX_LEAVES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(in_tvalid), .in_rdy(in_tready),
    .in_op(in_tuser), .in_cmd(in_cmd), .q_vld(q_vld), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  smrt_back #(
    .STORE_DEPTH(STORE_DEPTH), .MAX_LEAVES(MAX_LEAVES), .KEY_BITS(KEY_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_vld(q_vld), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_vld(out_tvalid), .out_res(res), .out_rdy(out_tready)
  );

  assign out_tdata = {7'd0, res.status, res.limit, res.first, res.row, res.key};
endmodule

FILE: sv/smrt_check.sv
// checker on the top level ports, bound to the top level
`timescale 1ns / 1ps
module smrt_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [87:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out valid dropped");
  a_hold_dat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("out data moved");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:65] == 7'd0) else $error("pad bits set");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[63:0] == 64'd0)
    else $error("rejected result carries data");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("out valid after reset");
endmodule

bind segment_merge_with_range_table smrt_check u_check (.*);

FILE: tb/sv/segment_merge_with_range_table_test.sv
// testbench: directed and random operations on the segment merge block, checked by a predictor
`timescale 1ns / 1ps
module segment_merge_with_range_table_test;
  import smrt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int SEGS = 2 * MAX_LEAVES_DEF + 1;
  localparam int CYCLE_LIMIT = 2000000;
  // operation codes with no meaning, answered as rejected
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [9:0] pos;
    logic [31:0] key;
    logic [9:0] row;
    logic [6:0] sa;
    logic [6:0] sb;
    logic [10:0] rf;
    logic [10:0] rl;
  } op_item_t;

  typedef struct {
    logic [31:0] key;
    logic [9:0] row;
    logic [10:0] first;
    logic [10:0] limit;
    logic status;
  } answer_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;

  // predictor state
  logic signed [31:0] store_key [DEPTH];
  logic [9:0] store_row [DEPTH];
  bit written [DEPTH];
  logic [10:0] seg_first [SEGS];
  logic [10:0] seg_limit [SEGS];

  answer_t expected_answers[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit steady_receiver = 0;

  segment_merge_with_range_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit merge_segments(input logic [6:0] ida, input logic [6:0] idb);
    int lft, rgt, ls, le, rs, re, rlen, i, j, n;
    logic [31:0] tk [DEPTH];
    logic [9:0] tr [DEPTH];
    bit tw [DEPTH];
    if (int'(ida) >= SEGS || int'(idb) >= SEGS) return 1;
    if (seg_first[ida] == seg_first[idb]) return 1;
    if (seg_first[ida] < seg_first[idb]) begin
      lft = int'(ida); rgt = int'(idb);
    end else begin
      lft = int'(idb); rgt = int'(ida);
    end
    ls = int'(seg_first[lft]); le = int'(seg_limit[lft]);
    rs = int'(seg_first[rgt]); re = int'(seg_limit[rgt]);
    if (ls > le || rs > re || le > rs || re > DEPTH) return 1;
    rlen = re - rs;
    n = 0; i = ls; j = rs;
    while (i < le || j < re) begin
      if (j >= re || (i < le && $signed(store_key[i]) <= $signed(store_key[j]))) begin
        tk[n] = store_key[i]; tr[n] = store_row[i]; tw[n] = written[i]; i++;
      end else begin
        tk[n] = store_key[j]; tr[n] = store_row[j]; tw[n] = written[j]; j++;
      end
      n++;
    end
    for (int k = re; k > le + rlen; k--) begin
      store_key[k-1] = store_key[k-1-rlen];
      store_row[k-1] = store_row[k-1-rlen];
      written[k-1] = written[k-1-rlen];
    end
    for (int k = 0; k < SEGS; k++)
      if (int'(seg_first[k]) >= le && int'(seg_limit[k]) <= rs) begin
        seg_first[k] = seg_first[k] + 11'(rlen);
        seg_limit[k] = seg_limit[k] + 11'(rlen);
      end
    for (int k = 0; k < n; k++) begin
      store_key[ls+k] = tk[k]; store_row[ls+k] = tr[k]; written[ls+k] = tw[k];
    end
    seg_first[lft] = 11'(ls); seg_limit[lft] = 11'(le + rlen);
    seg_first[rgt] = 11'(ls); seg_limit[rgt] = 11'(le + rlen);
    return 0;
  endfunction

  function automatic answer_t predict_answer(input op_item_t it);
    answer_t a = '{default: '0};
    case (it.op)
      OP_WR_ELEM: begin
        store_key[it.pos] = it.key; store_row[it.pos] = it.row; written[it.pos] = 1;
      end
      OP_RD_ELEM: begin
        a.key = store_key[it.pos]; a.row = store_row[it.pos];
      end
      OP_WR_SEG:
        if (int'(it.sa) < SEGS) begin
          seg_first[it.sa] = it.rf; seg_limit[it.sa] = it.rl;
        end else a.status = 1;
      OP_RD_SEG:
        if (int'(it.sa) < SEGS) begin
          a.first = seg_first[it.sa]; a.limit = seg_limit[it.sa];
        end else a.status = 1;
      OP_MERGE: a.status = merge_segments(it.sa, it.sb);
      default: a.status = 1;
    endcase
    return a;
  endfunction

  // every element a merge would move must have been written, so the read-back stays defined
  function automatic bit merge_is_defined(input op_item_t it);
    int lo, hi;
    if (int'(it.sa) >= SEGS || int'(it.sb) >= SEGS) return 1;
    lo = int'((seg_first[it.sa] < seg_first[it.sb]) ? seg_first[it.sa] : seg_first[it.sb]);
    hi = int'((seg_limit[it.sa] > seg_limit[it.sb]) ? seg_limit[it.sa] : seg_limit[it.sb]);
    for (int k = lo; k < hi && k < DEPTH; k++)
      if (!written[k]) return 0;
    return 1;
  endfunction

  // valid stays high after the transfer; callers drop it before any pause
  task automatic send_op(input op_item_t it);
    if (it.op == OP_RD_ELEM && !written[it.pos]) it.op = OP_WR_ELEM;
    if (it.op == OP_MERGE && !merge_is_defined(it)) it.op = OP_RD_SEG;
    in_tvalid <= 1;
    in_tuser <= it.op;
    in_tdata <= {it.rl, it.rf, it.sb, it.sa, it.row, it.key, it.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_answers.insert(expected_answers.size(), predict_answer(it));
  endtask

  // sender burst and gap pattern
  int burst_left = 0;
  task automatic send_paced(input op_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = int'($urandom_range(0, 6));
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 12));
    end
    burst_left--;
    send_op(it);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else if (steady_receiver) begin
      out_tready <= 1;
    end else begin
      out_tready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    answer_t got, exp_a;
    if (rst_n && out_tvalid && out_tready) begin
      got.key = out_tdata[31:0];
      got.row = out_tdata[41:32];
      got.first = out_tdata[52:42];
      got.limit = out_tdata[63:53];
      got.status = out_tdata[64];
      if (expected_answers.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_a = expected_answers.pop_front();
        if (got.key !== exp_a.key) begin
          $error("read_key expected %h got %h", exp_a.key, got.key); errors++;
        end
        if (got.row !== exp_a.row) begin
          $error("read_row expected %h got %h", exp_a.row, got.row); errors++;
        end
        if (got.first !== exp_a.first) begin
          $error("read_first expected %h got %h", exp_a.first, got.first); errors++;
        end
        if (got.limit !== exp_a.limit) begin
          $error("read_limit expected %h got %h", exp_a.limit, got.limit); errors++;
        end
        if (got.status !== exp_a.status) begin
          $error("status expected %b got %b", exp_a.status, got.status); errors++;
        end
      end
    end
  end

  function automatic op_item_t blank_op(input logic [2:0] op);
    op_item_t it = '{op: op, default: '0};
    return it;
  endfunction

  function automatic op_item_t elem_write(input int p, input logic [31:0] k, input int r);
    op_item_t it = blank_op(OP_WR_ELEM);
    it.pos = 10'(p); it.key = k; it.row = 10'(r);
    return it;
  endfunction

  function automatic op_item_t seg_write(input int s, input int f, input int l);
    op_item_t it = blank_op(OP_WR_SEG);
    it.sa = 7'(s); it.rf = 11'(f); it.rl = 11'(l);
    return it;
  endfunction

  function automatic op_item_t merge_op(input int a, input int b);
    op_item_t it = blank_op(OP_MERGE);
    it.sa = 7'(a); it.sb = 7'(b);
    return it;
  endfunction

  function automatic op_item_t seg_read(input int s);
    op_item_t it = blank_op(OP_RD_SEG);
    it.sa = 7'(s);
    return it;
  endfunction

  function automatic op_item_t elem_read(input int p);
    op_item_t it = blank_op(OP_RD_ELEM);
    it.pos = 10'(p);
    return it;
  endfunction

  task automatic test_directed();
    op_item_t it;
    send_op(seg_read(0));
    send_op(seg_read(SEGS - 1));
    send_op(seg_read(127));
    send_op(elem_write(0, 32'h8000_0000, 1023));
    send_op(elem_write(1023, 32'h7fff_ffff, 0));
    send_op(elem_read(0));
    send_op(elem_read(1023));
    send_op(elem_write(1, 32'h0001_0000, 5));
    send_op(elem_write(2, 32'h0001_0000, 6));
    send_op(elem_write(3, 32'hffff_0000, 7));
    send_op(seg_write(0, 0, 2));
    send_op(seg_write(1, 2, 2));
    send_op(seg_write(64, 2, 4));
    send_op(seg_write(65, 1, 1));
    // tie keys: left run first
    send_op(merge_op(64, 0));
    send_op(seg_read(64));
    send_op(seg_read(1));
    send_op(elem_read(1));
    send_op(merge_op(0, 64));
    send_op(merge_op(0, 100));
    send_op(seg_write(5, 2047, 2047));
    send_op(seg_read(5));
    it = blank_op(OP_BAD_FIRST); it.pos = 10'h3ff; send_op(it);
    it = blank_op(OP_BAD_LAST); send_op(it);
    send_op(merge_op(1, 1));
  endtask

  // well-formed merges: left run, gap with a nested segment, right run
  task automatic test_merges(input int rounds);
    int base, ll, gl, rl, sl, sg, sr;
    for (int r = 0; r < rounds; r++) begin
      ll = int'($urandom_range(0, 6)); gl = int'($urandom_range(0, 5));
      rl = int'($urandom_range(0, 6));
      base = (r == rounds - 1) ? DEPTH - (ll + gl + rl + 1) : int'($urandom_range(0, 900));
      sl = int'($urandom_range(0, 20)); sg = int'($urandom_range(21, 40));
      sr = int'($urandom_range(41, 64));
      for (int k = 0; k < ll + gl + rl; k++)
        send_paced(elem_write(base + k, ($urandom_range(0, 3) == 0) ?
          32'($urandom_range(0, 3)) - 32'd2 : $urandom, int'($urandom_range(0, 1023))));
      // sorted runs from sorted small keys
      for (int k = 0; k < ll; k++) send_paced(elem_write(base + k, 32'(k * 3 - 6), k));
      for (int k = 0; k < rl; k++) send_paced(elem_write(base + ll + gl + k, 32'(k * 2 - 5), k));
      send_paced(seg_write(sl, base, base + ll));
      send_paced(seg_write(sg, base + ll, base + ll + gl));
      send_paced(seg_write(sr, base + ll + gl + 1 - (ll == 0 && gl == 0 ? 0 : 1),
                           base + ll + gl + rl));
      if ($urandom_range(0, 1)) send_paced(merge_op(sl, sr));
      else send_paced(merge_op(sr, sl));
      send_paced(seg_read(sg));
      send_paced(seg_read(sl));
      send_paced(elem_read(base + int'($urandom_range(0, ll + gl + rl))));
    end
  endtask

  task automatic test_random(input int count);
    op_item_t it;
    for (int k = 0; k < count; k++) begin
      it.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)) :
                                             3'($urandom_range(OP_WR_ELEM, OP_MERGE));
      it.pos = 10'($urandom); it.key = $urandom; it.row = 10'($urandom);
      it.sa = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
      it.sb = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
      it.rf = 11'($urandom); it.rl = 11'($urandom);
      if (it.op == OP_WR_SEG && $urandom_range(0, 1)) begin
        it.rf = 11'($urandom_range(0, 1000)); it.rl = it.rf + 11'($urandom_range(0, 8));
      end
      send_paced(it);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int k = 0; k < 12; k++) send_op(seg_read(int'($urandom_range(0, 64))));
    wait_drained();
    steady_receiver = 1;
    for (int k = 0; k < 10; k++) send_op(seg_read(int'($urandom_range(0, 64))));
    wait_drained();
    steady_receiver = 0;
  endtask

  initial begin
    for (int k = 0; k < SEGS; k++) begin
      seg_first[k] = 0; seg_limit[k] = 0;
    end
    for (int k = 0; k < DEPTH; k++) written[k] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_merges(7);
    test_backpressure();
    test_random(95);
    wait_drained();
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/smrt_pkg.sv
sv/smrt_ram.sv
sv/smrt_front.sv
sv/smrt_back.sv
sv/segment_merge_with_range_table.sv
sv/smrt_check.sv
tb/sv/segment_merge_with_range_table_test.sv
